/* hdl/byte_range_header_parser_macros.svh */
// Assertion macros shared by the byte range header parser RTL.
// Include by bare file name; each macro expands to one labeled concurrent assertion.
`ifndef BYTE_RANGE_HEADER_PARSER_MACROS_SVH
`define BYTE_RANGE_HEADER_PARSER_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define BRHP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define BRHP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/brhp_pkg.sv */
// Package for the byte range header parser: scan state type, phase and verdict codes,
// and the "bytes=" prefix table. No dependencies.
`default_nettype none

package brhp_pkg;

    localparam logic [2:0] PREFIX_LEN = 3'd6;

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // parse phase codes
    localparam logic [1:0] PH_START  = 2'd0;
    localparam logic [1:0] PH_FIRST  = 2'd1;
    localparam logic [1:0] PH_SECOND = 2'd2;

    // verdict codes
    localparam logic [1:0] V_IGNORE = 2'd0;
    localparam logic [1:0] V_RANGE  = 2'd1;
    localparam logic [1:0] V_UNSAT  = 2'd2;

    typedef struct packed {
        logic [2:0]  prefix_pos;
        logic [1:0]  phase;
        logic        suffix_form;
        logic [63:0] first_value;
        logic [63:0] second_value;
        logic        first_has_digits;
        logic        second_has_digits;
        logic        number_overflow;
        logic        syntax_bad;
    } t_scan;

    function automatic logic [7:0] prefix_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0: ch = 8'h62; // b
            3'd1: ch = 8'h79; // y
            3'd2: ch = 8'h74; // t
            3'd3: ch = 8'h65; // e
            3'd4: ch = 8'h73; // s
            3'd5: ch = 8'h3D; // =
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

/* hdl/brhp_scan.sv */
// Character scanner: holds the parse state and advances it by one character per enable, or clears it on i_clear.
// Depends on brhp_pkg.
`default_nettype none

module brhp_scan (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_en,
    input  wire logic [7:0]   i_char,
    input  wire logic         i_clear,
    output brhp_pkg::t_scan   o_next
);
    import brhp_pkg::*;

    t_scan       r_state;
    t_scan       n_state;
    logic        is_digit;
    logic [3:0]  digit;
    logic        use_second;
    logic [63:0] acc;
    logic [67:0] acc_x10;
    logic [67:0] prod;
    logic        take_digit;

    always_comb begin
        is_digit   = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
        digit      = 4'(i_char - CH_ZERO);
        use_second = (r_state.phase != PH_START) && (r_state.phase != PH_FIRST);
        acc        = use_second ? r_state.second_value : r_state.first_value;
        acc_x10    = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0};
        prod       = acc_x10 + 68'(digit);
        take_digit = 1'b0;
        n_state    = r_state;

        if (i_char == CH_COMMA) begin
            n_state.syntax_bad = 1'b1;
        end

        if (!r_state.syntax_bad && (i_char != CH_COMMA)) begin
            if (r_state.prefix_pos < PREFIX_LEN) begin
                if (i_char == prefix_char(r_state.prefix_pos)) begin
                    n_state.prefix_pos = r_state.prefix_pos + 3'd1;
                end else begin
                    n_state.syntax_bad = 1'b1;
                end
            end else begin
                case (r_state.phase)
                    PH_START: begin
                        if (i_char == CH_DASH) begin
                            n_state.suffix_form = 1'b1;
                            n_state.phase       = PH_SECOND;
                        end else if (is_digit) begin
                            take_digit    = 1'b1;
                            n_state.phase = PH_FIRST;
                        end else begin
                            n_state.syntax_bad = 1'b1;
                        end
                    end
                    PH_FIRST: begin
                        if (is_digit) begin
                            take_digit = 1'b1;
                        end else if (i_char == CH_DASH) begin
                            n_state.phase = PH_SECOND;
                        end else begin
                            n_state.syntax_bad = 1'b1;
                        end
                    end
                    default: begin
                        if (is_digit) begin
                            take_digit = 1'b1;
                        end else begin
                            n_state.syntax_bad = 1'b1;
                        end
                    end
                endcase
            end
        end

        // accumulate a decimal digit; the value freezes once any number overflows
        if (take_digit) begin
            if (use_second) begin
                n_state.second_has_digits = 1'b1;
            end else begin
                n_state.first_has_digits = 1'b1;
            end
            if (!r_state.number_overflow) begin
                if (|prod[67:64]) begin
                    n_state.number_overflow = 1'b1;
                end else if (use_second) begin
                    n_state.second_value = prod[63:0];
                end else begin
                    n_state.first_value = prod[63:0];
                end
            end
        end
    end

    assign o_next = n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_en) begin
            r_state <= i_clear ? '0 : n_state;
        end
    end

endmodule

`default_nettype wire

/* hdl/byte_range_header_parser.sv */
// Byte range header parser: one header character per transaction, one verdict per value.
// The last character passes the input, judge and result registers to o_m_axis_tvalid.
// Throughput: one character per cycle; a last character waits for a free judge register.
// Stages: input register, scan state plus judge register, result register.
// Reset: i_rst_n synchronous active low; clears all valids and the parse state.
// Depends on brhp_pkg, brhp_scan and byte_range_header_parser_macros.svh.
`default_nettype none
`include "byte_range_header_parser_macros.svh"

module byte_range_header_parser #(
    parameter int SIZE_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [39:0] i_s_axis_tdata,  // [7:0] char_code, [39:8] resource_size
    input  wire logic        i_s_axis_tlast,  // last_char
    // result stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [63:0]      o_m_axis_tdata,  // [31:0] range_start, [63:32] range_length
    output logic [1:0]       o_m_axis_tuser   // verdict
);
    import brhp_pkg::*;

    // Width of the resource size actually used: the port is 32 bits.
    localparam int SZ_W = (SIZE_BITS < 32) ? SIZE_BITS : 32;

    // ---------------- handshake chain ----------------
    logic s_fire;
    logic out_adv;   // result register can take a new result
    logic j_adv;     // judge register can take a new snapshot
    logic in_go;     // input register item is consumed this cycle

    // input register
    logic              r_in_valid, n_in_valid;
    logic [7:0]        r_in_char;
    logic [SZ_W-1:0]   r_in_size;
    logic              r_in_last;

    // judge register: scan state after the last character, plus the size
    logic              r_j_valid, n_j_valid;
    t_scan             r_j;
    logic [SZ_W-1:0]   r_j_total;

    // result register
    logic              r_out_valid, n_out_valid;
    logic [1:0]        r_verdict, n_verdict;
    logic [31:0]       r_start, n_start;
    logic [31:0]       r_length, n_length;

    t_scan             scan_next;

    assign s_fire          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_adv         = !r_out_valid || i_m_axis_tready;
    assign j_adv           = !r_j_valid || out_adv;
    // A plain character only touches the scan state; the last one also needs the judge slot.
    assign in_go           = r_in_valid && (!r_in_last || j_adv);
    assign o_s_axis_tready = !r_in_valid || in_go;

    assign n_in_valid  = s_fire ? 1'b1 : (in_go ? 1'b0 : r_in_valid);
    assign n_j_valid   = (in_go && r_in_last) ? 1'b1 : (out_adv ? 1'b0 : r_j_valid);
    assign n_out_valid = out_adv ? r_j_valid : r_out_valid;

    // ---------------- scan ----------------
    // Advance the parse state per character; clear it after the last one.
    brhp_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (in_go),
        .i_char  (r_in_char),
        .i_clear (r_in_last),
        .o_next  (scan_next)
    );

    // ---------------- judge ----------------
    logic [63:0]     total64;
    logic [63:0]     b_open;
    logic            a_gt_b;
    logic            a_ge_t;
    logic            b_ge_t;
    logic            n_gt_t;
    logic [SZ_W-1:0] suf_len;
    logic [SZ_W-1:0] suf_start;
    logic [SZ_W-1:0] b_clamp;
    logic [SZ_W-1:0] ab_len;

    always_comb begin
        total64   = 64'(r_j_total);
        // open end defaults to size-1 (zero for an empty resource)
        b_open    = r_j.second_has_digits ? r_j.second_value
                  : ((r_j_total != '0) ? (total64 - 64'd1) : 64'd0);
        a_gt_b    = r_j.first_value > b_open;
        a_ge_t    = r_j.first_value >= total64;
        b_ge_t    = b_open >= total64;
        n_gt_t    = r_j.second_value > total64;
        // suffix length clamps to the size
        suf_len   = n_gt_t ? r_j_total : r_j.second_value[SZ_W-1:0];
        suf_start = r_j_total - suf_len;
        b_clamp   = b_ge_t ? (r_j_total - SZ_W'(1)) : b_open[SZ_W-1:0];
        ab_len    = b_clamp - r_j.first_value[SZ_W-1:0] + SZ_W'(1);

        n_verdict = V_IGNORE;
        n_start   = '0;
        n_length  = '0;
        if ((r_j.prefix_pos != PREFIX_LEN) || r_j.syntax_bad || r_j.number_overflow) begin
            n_verdict = V_IGNORE;
        end else if (r_j.suffix_form) begin
            if (!r_j.second_has_digits) begin
                n_verdict = V_IGNORE;
            end else if ((r_j.second_value == 64'd0) || (r_j_total == '0)) begin
                n_verdict = V_UNSAT;
            end else begin
                n_verdict = V_RANGE;
                n_start   = 32'(suf_start);
                n_length  = 32'(suf_len);
            end
        end else if (!r_j.first_has_digits || (r_j.phase != PH_SECOND)) begin
            n_verdict = V_IGNORE;
        end else if (a_gt_b || a_ge_t) begin
            n_verdict = V_UNSAT;
        end else begin
            n_verdict = V_RANGE;
            n_start   = 32'(r_j.first_value[SZ_W-1:0]);
            n_length  = 32'(ab_len);
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_j_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_j_valid   <= n_j_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        // hold the payload until the next accepted transaction
        if (s_fire) begin
            r_in_char <= i_s_axis_tdata[7:0];
            r_in_size <= i_s_axis_tdata[8 +: SZ_W];
            r_in_last <= i_s_axis_tlast;
        end
        // snapshot the state after the last character, with the sampled size
        if (in_go && r_in_last) begin
            r_j       <= scan_next;
            r_j_total <= r_in_size;
        end
        if (out_adv && r_j_valid) begin
            r_verdict <= n_verdict;
            r_start   <= n_start;
            r_length  <= n_length;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_verdict;
    assign o_m_axis_tdata  = {r_length, r_start};

    // ---------------- assertions ----------------
    `BRHP_ASSERT_IMP(a_zero_unless_range, o_m_axis_tvalid && (o_m_axis_tuser != V_RANGE), o_m_axis_tdata == 64'd0, "start/length nonzero without a range verdict")
    `BRHP_ASSERT_IMP(a_range_nonempty, o_m_axis_tvalid && (o_m_axis_tuser == V_RANGE), o_m_axis_tdata[63:32] != 32'd0, "range verdict with zero length")
    `BRHP_ASSERT_NXT(a_judge_held, r_j_valid && !out_adv, r_j_valid && $stable(r_j_total), "judge stage lost a stalled transaction")

endmodule

`default_nettype wire

/* bench/tb_byte_range_header_parser.sv */
// Self-checking bench for byte_range_header_parser: sends whole Range header values one
// character per transaction and scores each verdict against an in-bench scan predictor.
// Depends on brhp_pkg and the byte_range_header_parser RTL.
`timescale 1ns / 100ps

module tb_byte_range_header_parser;

    import brhp_pkg::*;

    // Cycles without any transaction on either side before the run is declared hung.
    localparam int unsigned STALL_LIMIT = 2000;
    // The range unit, first character in the top byte.
    localparam logic [47:0] UNIT_TEXT = "bytes=";

    typedef struct packed {
        logic [1:0]  verdict;
        logic [31:0] start;
        logic [31:0] length;
    } range_result_t;

    logic        i_clk;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [39:0] i_s_axis_tdata  = '0;   // [7:0] char_code, [39:8] resource_size
    logic        i_s_axis_tlast  = 1'b0; // last_char
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [63:0] o_m_axis_tdata;         // [31:0] range_start, [63:32] range_length
    logic [1:0]  o_m_axis_tuser;         // verdict

    // Predictor state: a private copy of the scan registers.
    t_scan         scan = '0;
    range_result_t verdict_q[$];
    logic [7:0]    hdr_text[$];
    int unsigned   err_count   = 0;
    int unsigned   chars_sent  = 0;
    int unsigned   idle_cycles = 0;
    int unsigned   ready_hold  = 0;
    bit            idling      = 1'b1;

    byte_range_header_parser #(.SIZE_BITS(32)) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Shift one decimal digit into an accumulator; freeze it once it passes 64 bits.
    task automatic add_digit(inout logic [63:0] acc, input logic [3:0] d);
        if (scan.number_overflow) return;
        if (acc > (64'hFFFF_FFFF_FFFF_FFFF - 64'(d)) / 64'd10)
            scan.number_overflow = 1'b1;
        else
            acc = acc * 64'd10 + 64'(d);
    endtask

    // Advance the scan state by one header character.
    task automatic scan_char(input logic [7:0] ch);
        logic       is_digit;
        logic [3:0] d;
        is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
        d = 4'(ch - CH_ZERO);
        // A comma poisons the value no matter where it shows up.
        if (ch == CH_COMMA) scan.syntax_bad = 1'b1;
        if (scan.syntax_bad) return;
        // Match the range unit first.
        if (scan.prefix_pos < PREFIX_LEN) begin
            if (ch != UNIT_TEXT[47 - 8 * scan.prefix_pos -: 8])
                scan.syntax_bad = 1'b1;
            else
                scan.prefix_pos = scan.prefix_pos + 3'd1;
            return;
        end
        case (scan.phase)
            PH_START: begin
                if (ch == CH_DASH) begin
                    scan.suffix_form = 1'b1;
                    scan.phase = PH_SECOND;
                end else if (is_digit) begin
                    scan.first_has_digits = 1'b1;
                    add_digit(scan.first_value, d);
                    scan.phase = PH_FIRST;
                end else begin
                    scan.syntax_bad = 1'b1;
                end
            end
            PH_FIRST: begin
                if (is_digit) begin
                    scan.first_has_digits = 1'b1;
                    add_digit(scan.first_value, d);
                end else if (ch == CH_DASH) begin
                    scan.phase = PH_SECOND;
                end else begin
                    scan.syntax_bad = 1'b1;
                end
            end
            default: begin
                // A second dash lands here and counts as junk.
                if (is_digit) begin
                    scan.second_has_digits = 1'b1;
                    add_digit(scan.second_value, d);
                end else begin
                    scan.syntax_bad = 1'b1;
                end
            end
        endcase
    endtask

    // Turn the finished scan plus the resource size into the verdict.
    function automatic range_result_t judge_range(input logic [31:0] size);
        range_result_t r;
        logic [63:0]   total, a, b;
        r = '{V_IGNORE, 32'd0, 32'd0};
        total = {32'd0, size};
        if (scan.prefix_pos < PREFIX_LEN || scan.syntax_bad || scan.number_overflow)
            return r;
        if (scan.suffix_form) begin
            if (!scan.second_has_digits) return r;
            b = scan.second_value;
            if (b == 64'd0 || total == 64'd0) begin
                r.verdict = V_UNSAT;
                return r;
            end
            // Clamp the suffix to the whole resource.
            if (b > total) b = total;
            r.verdict = V_RANGE;
            r.start   = 32'(total - b);
            r.length  = 32'(b);
            return r;
        end
        if (!scan.first_has_digits || scan.phase != PH_SECOND) return r;
        a = scan.first_value;
        // Open end means through the last byte.
        b = scan.second_has_digits ? scan.second_value
                                   : ((total != 64'd0) ? total - 64'd1 : 64'd0);
        if (a > b || a >= total) begin
            r.verdict = V_UNSAT;
            return r;
        end
        if (b >= total) b = total - 64'd1;
        r.verdict = V_RANGE;
        r.start   = 32'(a);
        r.length  = 32'(b - a + 64'd1);
        return r;
    endfunction

    // Feed every accepted character to the predictor; queue a verdict on the last one.
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            scan_char(i_s_axis_tdata[7:0]);
            if (i_s_axis_tlast) begin
                verdict_q.push_back(judge_range(i_s_axis_tdata[39:8]));
                // All scan state clears after the last character.
                scan = '0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    // Score each result transaction against the oldest queued verdict.
    always @(posedge i_clk) begin
        range_result_t want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (verdict_q.size() == 0) begin
                $error("result with no verdict pending: verdict %0d start %0d length %0d",
                       o_m_axis_tuser, o_m_axis_tdata[31:0], o_m_axis_tdata[63:32]);
                err_count++;
            end else begin
                want = verdict_q.pop_front();
                if (o_m_axis_tuser !== want.verdict) begin
                    $error("verdict: expected %0d, got %0d", want.verdict, o_m_axis_tuser);
                    err_count++;
                end
                if (o_m_axis_tdata[31:0] !== want.start) begin
                    $error("range_start: expected %0d, got %0d",
                           want.start, o_m_axis_tdata[31:0]);
                    err_count++;
                end
                if (o_m_axis_tdata[63:32] !== want.length) begin
                    $error("range_length: expected %0d, got %0d",
                           want.length, o_m_axis_tdata[63:32]);
                    err_count++;
                end
            end
        end
    end

    // Hang detector: count cycles in which neither side moves a transaction.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Idling on both sides
    // ------------------------------------------------------------------

    // Mostly no gap, some short ones, a few long ones; none while idling is off.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (!idling) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver back-pressure: drop tready for a random stretch now and then.
    always @(posedge i_clk) begin
        if (idling && ready_hold != 0) begin
            i_m_axis_tready <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else begin
            i_m_axis_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) ready_hold <= pick_gap();
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Send one character transaction, with an optional idle gap ahead of it.
    // Hold tvalid high across back-to-back characters rather than toggling it.
    task automatic send_char(input logic [7:0] ch, input logic [31:0] size,
                             input logic last);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tdata  <= {size, ch};
        i_s_axis_tlast  <= last;
        i_s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        chars_sent++;
    endtask

    // Send the buffered header value; only the last character carries the real size.
    task automatic send_header(input logic [31:0] size);
        for (int i = 0; i < hdr_text.size(); i++) begin
            if (i == hdr_text.size() - 1)
                send_char(hdr_text[i], size, 1'b1);
            else
                send_char(hdr_text[i], $urandom, 1'b0);
        end
    endtask

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++) hdr_text.push_back(s[i]);
    endtask

    // Append a decimal number, sometimes with leading zeros.
    task automatic put_num(input logic [63:0] v);
        logic [7:0] digits[$];
        if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 3)) hdr_text.push_back(CH_ZERO);
        if (v == 64'd0) digits.push_back(CH_ZERO);
        while (v != 64'd0) begin
            digits.push_front(CH_ZERO + 8'(v % 64'd10));
            v = v / 64'd10;
        end
        foreach (digits[i]) hdr_text.push_back(digits[i]);
    endtask

    // Append a long number near or past the 64-bit limit.
    task automatic put_huge();
        case ($urandom_range(0, 3))
            0: put_str("18446744073709551615");
            1: put_str("18446744073709551616");
            2: put_str("99999999999999999999");
            default: begin
                hdr_text.push_back(CH_ZERO + 8'($urandom_range(1, 9)));
                repeat ($urandom_range(18, 23))
                    hdr_text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            end
        endcase
    endtask

    // Resource sizes: empty, one byte, small, random and the full 32-bit maximum.
    function automatic logic [31:0] pick_size();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'd1;
            2, 3, 4, 5: return $urandom_range(1, 5000);
            9: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Offsets and lengths clustered around the interesting points of the size.
    function automatic logic [63:0] pick_offset(input logic [31:0] size);
        case ($urandom_range(0, 7))
            0: return 64'd0;
            1, 2, 3: return (size == 0) ? 64'd0 : 64'($urandom_range(0, size - 1));
            4: return 64'(size);
            5: return 64'(size) - 64'd1;
            6: return 64'(size) + 64'($urandom_range(1, 1000));
            default: return {$urandom, $urandom} >> $urandom_range(0, 63);
        endcase
    endfunction

    // Break a well-formed value in one of several ways.
    task automatic corrupt_header();
        int unsigned p;
        p = $urandom_range(0, hdr_text.size() - 1);
        case ($urandom_range(0, 6))
            0: hdr_text.insert(p, CH_COMMA);
            1: while (hdr_text.size() > p + 1) void'(hdr_text.pop_back());
            2: hdr_text[p] = 8'($urandom);
            3: hdr_text.push_back(CH_DASH);
            4: hdr_text.push_back(8'($urandom));
            5: hdr_text.insert(p, 8'h00);
            default: if (hdr_text.size() > 1) hdr_text.delete(p);
        endcase
    endtask

    // Build one random header value: mostly well-formed, the rest overflow, broken or noise.
    task automatic build_random_header(output logic [31:0] size);
        int unsigned kind;
        size = pick_size();
        hdr_text.delete();
        kind = $urandom_range(0, 99);
        if (kind < 40) begin
            put_str("bytes=");
            put_num(pick_offset(size));
            hdr_text.push_back(CH_DASH);
            if ($urandom_range(0, 3) != 0) put_num(pick_offset(size));
        end else if (kind < 65) begin
            put_str("bytes=-");
            put_num(pick_offset(size));
        end else if (kind < 75) begin
            put_str("bytes=");
            case ($urandom_range(0, 2))
                0: begin
                    put_huge();
                    hdr_text.push_back(CH_DASH);
                end
                1: begin
                    hdr_text.push_back(CH_DASH);
                    put_huge();
                end
                default: begin
                    put_num(pick_offset(size));
                    hdr_text.push_back(CH_DASH);
                    put_huge();
                end
            endcase
        end else if (kind < 92) begin
            put_str("bytes=");
            if ($urandom_range(0, 1) == 0) put_num(pick_offset(size));
            hdr_text.push_back(CH_DASH);
            put_num(pick_offset(size));
            corrupt_header();
        end else begin
            repeat ($urandom_range(1, 12)) hdr_text.push_back(8'($urandom));
        end
    endtask

    task automatic send_text(input string s, input logic [31:0] size);
        hdr_text.delete();
        put_str(s);
        send_header(size);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-picked values: field extremes and each corner of the grammar.
    task automatic test_directed_cases();
        send_text("bytes=0-0", 32'd1);                       // one-byte range
        send_text("bytes=0-", 32'hFFFF_FFFF);                // open end, largest size
        send_text("bytes=0-0", 32'd0);                       // empty resource, start form
        send_text("bytes=-5", 32'd0);                        // empty resource, suffix form
        send_text("bytes=-0", 32'd100);                      // zero-length suffix
        send_text("bytes=-500", 32'd100);                    // suffix clamped to size
        send_text("bytes=-99999999999", 32'hFFFF_FFFF);      // big suffix, largest size
        send_text("bytes=10-5", 32'd100);                    // start past end
        send_text("bytes=100-", 32'd100);                    // start at size
        send_text("bytes=10-4294967295", 32'hFFFF_FFFF);     // end clamped to size-1
        send_text("bytes=18446744073709551615-", 32'd50);    // 64-bit max, no overflow
        send_text("bytes=18446744073709551616-", 32'd50);    // overflow
        send_text("bytes=-", 32'd50);                        // missing suffix length
        send_text("bytes=-7", 32'd50);                       // plain suffix
        send_text("bytes=5", 32'd50);                        // missing dash
        send_text("bytes=", 32'd50);                         // missing first number
        send_text("byt", 32'd50);                            // ends inside the unit
        send_text("Bytes=0-1", 32'd50);                      // wrong unit
        send_text("bytes=1-2,3-4", 32'd50);                  // comma, two ranges
        send_text(",", 32'd50);                              // lone comma
        send_text("bytes=1--2", 32'd50);                     // second dash
        send_text("bytes=1-2x", 32'd50);                     // trailing junk
        hdr_text.delete();
        put_str("bytes=1");
        hdr_text.push_back(8'h00);                           // zero byte is junk
        put_str("-2");
        send_header(32'd50);
        hdr_text.delete();
        hdr_text.push_back(8'hFF);                           // top character code
        send_header(32'hFFFF_FFFF);
    endtask

    // Random header values with idling on both sides.
    task automatic test_random_ranges(input int unsigned n_chars);
        int unsigned stop_at;
        logic [31:0] size;
        stop_at = chars_sent + n_chars;
        while (chars_sent < stop_at) begin
            build_random_header(size);
            send_header(size);
        end
    endtask

    // Same mix with no gaps and no back-pressure: full-rate streaming.
    task automatic test_back_to_back(input int unsigned n_chars);
        idling <= 1'b0;
        test_random_ranges(n_chars);
        idling <= 1'b1;
    endtask

    // Raw random bytes with random last marks; close with a last character.
    task automatic test_noise(input int unsigned n_chars);
        repeat (n_chars) send_char(8'($urandom), $urandom, $urandom_range(0, 7) == 0);
        send_char(8'($urandom), $urandom, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        // Hold reset low from time zero, then release it once for the whole run.
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_random_ranges(950);
        test_back_to_back(250);
        test_noise(200);
        i_s_axis_tvalid <= 1'b0;

        // Drain: let the last verdict get queued, wait for it, then allow for latency.
        @(posedge i_clk);
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (err_count == 0 && verdict_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
